// File: rtl/itaf_pkg.sv
`timescale 1ns / 1ps
package itaf_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int MAX_WIDTH_DEF  = 60;
    localparam int QUEUE_DEPTH    = 2;

    localparam int MAG_W = 32;   // magnitude port width
    localparam int CW    = 6;    // character positions, up to 63 per run

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UB    = 8'h42;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_LX    = 8'h78;

    typedef enum logic [1:0] {
        BS_DEC = 2'd0,
        BS_HEX = 2'd1,
        BS_OCT = 2'd2,
        BS_BIN = 2'd3
    } t_base;

    typedef enum logic [1:0] {
        SG_NONE,
        SG_MINUS,
        SG_PLUS,
        SG_SPACE
    } t_sign;

    typedef enum logic [1:0] {
        PF_NONE,
        PF_ZERO,
        PF_HEX,
        PF_BIN
    } t_pfx;

    typedef struct packed {
        t_base           base;
        logic            upper;
        logic            left;
        logic            zfill;   // zero pad, already cleared when left aligned
        t_sign           sign;
        t_pfx            pfx;
        logic [CW-1:0]   width;   // saturated field width
    } t_ctl;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CONV,
        BK_NORM,
        BK_SETUP,
        BK_EMIT
    } t_bstate;

    function automatic logic [7:0] digit_ascii(input logic [3:0] d, input logic upper);
        logic [7:0] base_ch;
        base_ch = upper ? CH_UA : CH_LA;
        if (d < 4'd10) begin
            digit_ascii = CH_ZERO + {4'b0, d};
        end else begin
            digit_ascii = base_ch + {4'b0, d} - 8'd10;
        end
    endfunction

endpackage

// File: rtl/itaf_front.sv
`timescale 1ns / 1ps
module itaf_front #(
    parameter int VALUE_BITS = itaf_pkg::VALUE_BITS_DEF,
    parameter int MAX_WIDTH  = itaf_pkg::MAX_WIDTH_DEF
) (
    input  logic [itaf_pkg::MAG_W-1:0] i_magnitude,
    input  logic                       i_negative,
    input  logic [1:0]                 i_base_select,
    input  logic                       i_upper_case,
    input  logic                       i_left_align,
    input  logic                       i_force_sign,
    input  logic                       i_space_sign,
    input  logic                       i_zero_pad,
    input  logic                       i_alternate_form,
    input  logic [5:0]                 i_field_width,
    output itaf_pkg::t_ctl             o_ctl,
    output logic [VALUE_BITS-1:0]      o_value
);
    import itaf_pkg::*;

    logic  nonzero;
    t_base base;

    assign o_value = VALUE_BITS'(i_magnitude);
    assign nonzero = |o_value;
    assign base    = t_base'(i_base_select);

    always_comb begin
        o_ctl       = '0;
        o_ctl.base  = base;
        o_ctl.upper = i_upper_case;
        o_ctl.left  = i_left_align;
        o_ctl.zfill = i_zero_pad & ~i_left_align;
        o_ctl.width = (i_field_width > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : i_field_width;

        if (i_negative) begin
            o_ctl.sign = SG_MINUS;
        end else if (i_force_sign) begin
            o_ctl.sign = SG_PLUS;
        end else if (i_space_sign) begin
            o_ctl.sign = SG_SPACE;
        end else begin
            o_ctl.sign = SG_NONE;
        end

        // a zero value gets no prefix in any base, only its single 0 digit
        o_ctl.pfx = PF_NONE;
        if (i_alternate_form && nonzero) begin
            case (base)
                BS_HEX:  o_ctl.pfx = PF_HEX;
                BS_BIN:  o_ctl.pfx = PF_BIN;
                BS_OCT:  o_ctl.pfx = PF_ZERO;
                default: o_ctl.pfx = PF_NONE;
            endcase
        end
    end

endmodule

// File: rtl/itaf_queue.sv
`timescale 1ns / 1ps
module itaf_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = itaf_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, r_rptr;
    logic [NW-1:0]    r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == NW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// File: rtl/itaf_back.sv
`timescale 1ns / 1ps
module itaf_back #(
    parameter int VALUE_BITS = itaf_pkg::VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_job_valid,
    input  itaf_pkg::t_ctl        i_ctl,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic                  o_pop,
    output logic                  o_valid,
    output logic [7:0]            o_character,
    output logic                  o_last
);
    import itaf_pkg::*;

    // digit slots per base; the digit register holds the decimal BCD in full
    localparam int NS_BIN = VALUE_BITS;
    localparam int NS_OCT = (VALUE_BITS + 2) / 3;
    localparam int NS_HEX = (VALUE_BITS + 3) / 4;
    localparam int NS_DEC = VALUE_BITS / 3 + 1;
    localparam int DW     = 4 * NS_DEC;
    localparam int SH_BIN = DW - NS_BIN;
    localparam int SH_OCT = DW - 3 * NS_OCT;
    localparam int SH_HEX = DW - 4 * NS_HEX;
    localparam int ITW    = $clog2(VALUE_BITS);

    t_bstate               r_state, n_state;
    t_ctl                  r_ctl, n_ctl;
    logic [DW-1:0]         r_dig, n_dig;
    logic [VALUE_BITS-1:0] r_bin, n_bin;
    logic [ITW-1:0]        r_it, n_it;
    logic [CW-1:0]         r_nd, n_nd;
    logic [CW-1:0]         r_pos, n_pos;
    logic [CW-1:0]         r_bsign, r_bpre, r_bzero, r_bdig, r_btsp, r_blast;
    logic [CW-1:0]         n_bsign, n_bpre, n_bzero, n_bdig, n_btsp, n_blast;

    logic [DW-1:0]         bcd_adj, dig_shift;
    logic [3:0]            top_digit;
    logic [CW-1:0]         s_cnt, p_cnt, body, pad, lspc, zcnt, tspc;

    always_comb begin
        for (int i = 0; i < NS_DEC; i++) begin
            bcd_adj[4*i +: 4] = (r_dig[4*i +: 4] >= 4'd5) ? r_dig[4*i +: 4] + 4'd3
                                                          : r_dig[4*i +: 4];
        end
    end

    always_comb begin
        case (r_ctl.base)
            BS_BIN: begin
                top_digit = {3'b0, r_dig[DW-1]};
                dig_shift = r_dig << 1;
            end
            BS_OCT: begin
                top_digit = {1'b0, r_dig[DW-1 -: 3]};
                dig_shift = r_dig << 3;
            end
            default: begin
                top_digit = r_dig[DW-1 -: 4];
                dig_shift = r_dig << 4;
            end
        endcase
    end

    // field layout
    always_comb begin
        s_cnt = (r_ctl.sign != SG_NONE) ? CW'(1) : '0;
        case (r_ctl.pfx)
            PF_NONE: p_cnt = '0;
            PF_ZERO: p_cnt = CW'(1);
            default: p_cnt = CW'(2);
        endcase
        body = s_cnt + p_cnt + r_nd;
        pad  = (r_ctl.width > body) ? r_ctl.width - body : '0;
        zcnt = r_ctl.zfill ? pad : '0;
        tspc = r_ctl.left ? pad : '0;
        lspc = (r_ctl.left || r_ctl.zfill) ? '0 : pad;
    end

    always_comb begin
        n_state = r_state;
        n_ctl   = r_ctl;
        n_dig   = r_dig;
        n_bin   = r_bin;
        n_it    = r_it;
        n_nd    = r_nd;
        n_pos   = r_pos;
        n_bsign = r_bsign;
        n_bpre  = r_bpre;
        n_bzero = r_bzero;
        n_bdig  = r_bdig;
        n_btsp  = r_btsp;
        n_blast = r_blast;
        o_pop   = 1'b0;

        case (r_state)
            BK_IDLE: begin
                if (i_job_valid) begin
                    o_pop = 1'b1;
                    n_ctl = i_ctl;
                    n_bin = i_value;
                    n_it  = '0;
                    case (i_ctl.base)
                        BS_BIN: begin
                            n_dig   = DW'(i_value) << SH_BIN;
                            n_nd    = CW'(NS_BIN);
                            n_state = BK_NORM;
                        end
                        BS_OCT: begin
                            n_dig   = DW'(i_value) << SH_OCT;
                            n_nd    = CW'(NS_OCT);
                            n_state = BK_NORM;
                        end
                        BS_HEX: begin
                            n_dig   = DW'(i_value) << SH_HEX;
                            n_nd    = CW'(NS_HEX);
                            n_state = BK_NORM;
                        end
                        default: begin
                            n_dig   = '0;
                            n_nd    = CW'(NS_DEC);
                            n_state = BK_CONV;
                        end
                    endcase
                end
            end
            BK_CONV: begin
                // double dabble, one bit per cycle
                n_dig = {bcd_adj[DW-2:0], r_bin[VALUE_BITS-1]};
                n_bin = r_bin << 1;
                n_it  = r_it + 1'b1;
                if (r_it == ITW'(VALUE_BITS - 1)) begin
                    n_state = BK_NORM;
                end
            end
            BK_NORM: begin
                // drop leading zero digits, keep at least one
                if (top_digit == 4'd0 && r_nd != CW'(1)) begin
                    n_dig = dig_shift;
                    n_nd  = r_nd - 1'b1;
                end else begin
                    n_state = BK_SETUP;
                end
            end
            BK_SETUP: begin
                n_bsign = lspc;
                n_bpre  = lspc + s_cnt;
                n_bzero = lspc + s_cnt + p_cnt;
                n_bdig  = lspc + s_cnt + p_cnt + zcnt;
                n_btsp  = lspc + s_cnt + p_cnt + zcnt + r_nd;
                n_blast = lspc + body + zcnt + tspc - 1'b1;
                n_pos   = '0;
                n_state = BK_EMIT;
            end
            BK_EMIT: begin
                n_pos = r_pos + 1'b1;
                if (r_pos >= r_bdig && r_pos < r_btsp) begin
                    n_dig = dig_shift;
                end
                if (r_pos == r_blast) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_valid = (r_state == BK_EMIT);
        o_last  = o_valid && (r_pos == r_blast);
        if (r_pos < r_bsign) begin
            o_character = CH_SPACE;
        end else if (r_pos < r_bpre) begin
            case (r_ctl.sign)
                SG_MINUS: o_character = CH_MINUS;
                SG_PLUS:  o_character = CH_PLUS;
                default:  o_character = CH_SPACE;
            endcase
        end else if (r_pos < r_bzero) begin
            if (r_pos == r_bpre) begin
                o_character = CH_ZERO;
            end else if (r_ctl.pfx == PF_BIN) begin
                o_character = r_ctl.upper ? CH_UB : CH_LB;
            end else begin
                o_character = r_ctl.upper ? CH_UX : CH_LX;
            end
        end else if (r_pos < r_bdig) begin
            o_character = CH_ZERO;
        end else if (r_pos < r_btsp) begin
            o_character = digit_ascii(top_digit, r_ctl.upper);
        end else begin
            o_character = CH_SPACE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctl   <= n_ctl;
        r_dig   <= n_dig;
        r_bin   <= n_bin;
        r_it    <= n_it;
        r_nd    <= n_nd;
        r_pos   <= n_pos;
        r_bsign <= n_bsign;
        r_bpre  <= n_bpre;
        r_bzero <= n_bzero;
        r_bdig  <= n_bdig;
        r_btsp  <= n_btsp;
        r_blast <= n_blast;
    end

endmodule

// File: rtl/integer_to_ascii_formatter_unit.sv
`timescale 1ns / 1ps
// Flow: a queued job is loaded by the back end from idle; decimal values then pass the BCD
//   converter (none for hex/octal/binary), leading zero digits are stripped one at a time,
//   the layout is set, and the characters are strobed out.
// Jobs: the back end takes a new job only when idle, after the last character of the current
//   one; the queue holds further jobs meanwhile. Its BCD converter works one bit per cycle.
// Reset: synchronous, active low; clears queue pointers and back-end state. No stall.
module integer_to_ascii_formatter_unit #(
    parameter int VALUE_BITS = itaf_pkg::VALUE_BITS_DEF,
    parameter int MAX_WIDTH  = itaf_pkg::MAX_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [itaf_pkg::MAG_W-1:0] i_magnitude,
    input  logic                       i_negative,
    input  logic [1:0]                 i_base_select,
    input  logic                       i_upper_case,
    input  logic                       i_left_align,
    input  logic                       i_force_sign,
    input  logic                       i_space_sign,
    input  logic                       i_zero_pad,
    input  logic                       i_alternate_form,
    input  logic [5:0]                 i_field_width,
    output logic                       o_valid,
    output logic [7:0]                 o_character,
    output logic                       o_last
);
    import itaf_pkg::*;

    localparam int JW = $bits(t_ctl) + VALUE_BITS;

    // front end: classification of the incoming transaction
    t_ctl                  f_ctl, q_ctl;
    logic [VALUE_BITS-1:0] f_value, q_value;
    logic                  q_full, q_valid, q_pop;
    logic [JW-1:0]         q_data;

    itaf_front #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_front (
        .i_magnitude      (i_magnitude),
        .i_negative       (i_negative),
        .i_base_select    (i_base_select),
        .i_upper_case     (i_upper_case),
        .i_left_align     (i_left_align),
        .i_force_sign     (i_force_sign),
        .i_space_sign     (i_space_sign),
        .i_zero_pad       (i_zero_pad),
        .i_alternate_form (i_alternate_form),
        .i_field_width    (i_field_width),
        .o_ctl            (f_ctl),
        .o_value          (f_value)
    );

    // short job queue; busy only while it is full
    itaf_queue #(
        .WIDTH (JW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (start & ~q_full),
        .i_data  ({f_ctl, f_value}),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign busy    = q_full;
    assign q_ctl   = t_ctl'(q_data[JW-1:VALUE_BITS]);
    assign q_value = q_data[VALUE_BITS-1:0];

    // back end: digit conversion, layout and character output
    itaf_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_ctl       (q_ctl),
        .i_value     (q_value),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .o_character (o_character),
        .o_last      (o_last)
    );

    // a run of characters is contiguous until its last one
    a_run_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |=> o_valid)
        else $error("character run broken before last");

    // the back end returns to idle between runs
    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |=> !o_valid)
        else $error("new run started without idle cycle");

    // only printable characters of the formatter's set are produced
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_character >= CH_SPACE && o_character <= CH_LX))
        else $error("character outside formatter set");

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// Integer-to-ASCII formatter: a directed set of corner cases, then a long random stream.
// Each accepted transaction is turned into its expected character string up front.
// Every strobed character is checked against the oldest pending one, last flag included.
module testbench;
    import itaf_pkg::*;

    // One formatting request, as driven on the input ports
    typedef struct {
        logic [31:0] magnitude;
        logic        negative;
        t_base       base;
        logic        upper;
        logic        left;
        logic        plus;
        logic        space;
        logic        zpad;
        logic        alt;
        logic [5:0]  width;
    } t_fmt_req;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } t_char;

    typedef logic [7:0] t_text_q[$];

    // Scoreboard: renders each request into the characters it must produce
    class ascii_scoreboard;
        t_char pending[$];
        int    mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Field layout: [spaces] sign prefix [zeros] digits [spaces]
        function automatic void render_field(input t_fmt_req r, output t_text_q text);
            string       lc = "0123456789abcdef";
            string       uc = "0123456789ABCDEF";
            logic [31:0] v;
            int unsigned radix;
            int unsigned dval;
            t_text_q     digs;
            t_text_q     pfx;
            logic [7:0]  sgn;
            int          fw;
            int          body;
            int          zeros;
            int          spaces;
            v = r.magnitude;
            case (r.base)
                BS_HEX: radix = 16;
                BS_OCT: radix = 8;
                BS_BIN: radix = 2;
                default: radix = 10;
            endcase
            digs = {};
            do begin
                dval = v % radix;
                digs.push_front(r.upper ? uc[dval] : lc[dval]);
                v = v / radix;
            end while (v != 0);
            // minus beats plus, plus beats space
            sgn = 8'h00;
            if (r.negative) sgn = CH_MINUS;
            else if (r.plus) sgn = CH_PLUS;
            else if (r.space) sgn = CH_SPACE;
            // no prefix on a zero value; decimal never gets one
            pfx = {};
            if (r.alt && r.magnitude != 0) begin
                case (r.base)
                    BS_HEX: begin
                        pfx.push_back(CH_ZERO);
                        pfx.push_back(r.upper ? CH_UX : CH_LX);
                    end
                    BS_BIN: begin
                        pfx.push_back(CH_ZERO);
                        pfx.push_back(r.upper ? CH_UB : CH_LB);
                    end
                    BS_OCT: pfx.push_back(CH_ZERO);
                    default: ;
                endcase
            end
            fw = (r.width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(r.width);
            body = ((sgn != 8'h00) ? 1 : 0) + pfx.size() + digs.size();
            zeros = 0;
            spaces = 0;
            if (fw > body) begin
                if (r.zpad && !r.left) zeros = fw - body;
                else spaces = fw - body;
            end
            text = {};
            if (!r.left) repeat (spaces) text.push_back(CH_SPACE);
            if (sgn != 8'h00) text.push_back(sgn);
            foreach (pfx[i]) text.push_back(pfx[i]);
            repeat (zeros) text.push_back(CH_ZERO);
            foreach (digs[i]) text.push_back(digs[i]);
            if (r.left) repeat (spaces) text.push_back(CH_SPACE);
        endfunction

        function void note_request(t_fmt_req r);
            t_text_q text;
            t_char   c;
            render_field(r, text);
            foreach (text[i]) begin
                c.ch = text[i];
                c.last = (i == text.size() - 1);
                pending.push_back(c);
            end
        endfunction

        function void check_char(logic [7:0] ch, logic last);
            t_char want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected char: expected none, got %h last %0b",
                         $time, ch, last);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            if (ch !== want.ch || last !== want.last) begin
                $display("%0t: char mismatch: expected %h last %0b, got %h last %0b",
                         $time, want.ch, want.last, ch, last);
                mismatches++;
            end
        endfunction
    endclass

    // DUT inputs, all driven to known values from time zero
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] i_magnitude = '0;
    logic        i_negative = 1'b0;
    logic [1:0]  i_base_select = '0;
    logic        i_upper_case = 1'b0;
    logic        i_left_align = 1'b0;
    logic        i_force_sign = 1'b0;
    logic        i_space_sign = 1'b0;
    logic        i_zero_pad = 1'b0;
    logic        i_alternate_form = 1'b0;
    logic [5:0]  i_field_width = '0;
    logic        o_valid;
    logic [7:0]  o_character;
    logic        o_last;

    ascii_scoreboard board = new();

    integer_to_ascii_formatter_unit u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_magnitude      (i_magnitude),
        .i_negative       (i_negative),
        .i_base_select    (i_base_select),
        .i_upper_case     (i_upper_case),
        .i_left_align     (i_left_align),
        .i_force_sign     (i_force_sign),
        .i_space_sign     (i_space_sign),
        .i_zero_pad       (i_zero_pad),
        .i_alternate_form (i_alternate_form),
        .i_field_width    (i_field_width),
        .o_valid          (o_valid),
        .o_character      (o_character),
        .o_last           (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: worst case is well under a tenth of this
    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Output monitor: the strobe lasts one cycle, sample it at the closing edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) board.check_char(o_character, o_last);
    end

    function automatic t_fmt_req mk_req(logic [31:0] mag, logic neg, t_base b, logic up,
                                        logic lft, logic pls, logic spc, logic zp,
                                        logic alt, logic [5:0] w);
        t_fmt_req r;
        r.magnitude = mag;
        r.negative = neg;
        r.base = b;
        r.upper = up;
        r.left = lft;
        r.plus = pls;
        r.space = spc;
        r.zpad = zp;
        r.alt = alt;
        r.width = w;
        return r;
    endfunction

    // Random request: magnitudes spread over sizes, widths biased toward the useful range
    function automatic t_fmt_req rand_req();
        t_fmt_req r;
        case ($urandom_range(0, 4))
            0: r.magnitude = $urandom_range(0, 20);
            1: r.magnitude = $urandom;
            2: r.magnitude = $urandom >> $urandom_range(0, 31);
            3: r.magnitude = 32'h1 << $urandom_range(0, 31);
            default: r.magnitude = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
        endcase
        r.negative = $urandom_range(0, 3) == 0;
        r.base = t_base'($urandom_range(0, 3));
        r.upper = 1'($urandom_range(0, 1));
        r.left = 1'($urandom_range(0, 1));
        r.plus = 1'($urandom_range(0, 1));
        r.space = 1'($urandom_range(0, 1));
        r.zpad = 1'($urandom_range(0, 1));
        r.alt = 1'($urandom_range(0, 1));
        r.width = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                              : 6'($urandom_range(0, 24));
        return r;
    endfunction

    // Present one transaction and hold it until start && !busy at an edge
    task automatic send_req(t_fmt_req r);
        start <= 1'b1;
        i_magnitude <= r.magnitude;
        i_negative <= r.negative;
        i_base_select <= r.base;
        i_upper_case <= r.upper;
        i_left_align <= r.left;
        i_force_sign <= r.plus;
        i_space_sign <= r.space;
        i_zero_pad <= r.zpad;
        i_alternate_form <= r.alt;
        i_field_width <= r.width;
        do @(posedge i_clk); while (busy !== 1'b0);
        board.note_request(r);
    endtask

    task automatic idle_for(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    t_fmt_req directed[$];
    int       guard;

    initial begin
        // reset: held low from time zero, then released once for good
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero value in every base, alternate form on hex, octal and binary (no prefix expected)
        directed.push_back(mk_req(32'd0, 0, BS_DEC, 0, 0, 0, 0, 0, 0, 6'd0));
        directed.push_back(mk_req(32'd0, 0, BS_HEX, 1, 0, 0, 0, 0, 1, 6'd0));
        directed.push_back(mk_req(32'd0, 0, BS_OCT, 0, 0, 0, 0, 0, 1, 6'd3));
        directed.push_back(mk_req(32'd0, 0, BS_BIN, 0, 0, 0, 0, 0, 1, 6'd0));
        // all-ones magnitude in every base
        directed.push_back(mk_req(32'hFFFF_FFFF, 1, BS_DEC, 0, 0, 0, 0, 0, 0, 6'd0));
        directed.push_back(mk_req(32'hFFFF_FFFF, 0, BS_HEX, 1, 0, 0, 0, 0, 1, 6'd0));
        directed.push_back(mk_req(32'hFFFF_FFFF, 0, BS_BIN, 0, 0, 0, 0, 0, 1, 6'd63));
        directed.push_back(mk_req(32'hFFFF_FFFF, 0, BS_OCT, 0, 0, 0, 0, 0, 1, 6'd0));
        directed.push_back(mk_req(32'hDEAD_BEEF, 0, BS_HEX, 0, 0, 0, 0, 1, 1, 6'd20));
        // sign selection and its precedence
        directed.push_back(mk_req(32'd123, 0, BS_DEC, 0, 0, 1, 0, 0, 0, 6'd10));
        directed.push_back(mk_req(32'd123, 0, BS_DEC, 0, 1, 0, 1, 0, 0, 6'd10));
        directed.push_back(mk_req(32'd123, 1, BS_DEC, 0, 0, 1, 1, 0, 0, 6'd0));
        directed.push_back(mk_req(32'd5, 0, BS_HEX, 0, 0, 1, 1, 0, 0, 6'd0));
        // zero pad ignored under left align, honored otherwise
        directed.push_back(mk_req(32'd42, 0, BS_DEC, 0, 1, 0, 0, 1, 0, 6'd12));
        directed.push_back(mk_req(32'd42, 1, BS_DEC, 0, 0, 0, 0, 1, 0, 6'd12));
        // width saturation and the maximum width
        directed.push_back(mk_req(32'd0, 0, BS_DEC, 0, 1, 0, 0, 0, 0, 6'd63));
        directed.push_back(mk_req(32'd0, 1, BS_BIN, 0, 0, 0, 0, 1, 1, 6'd63));
        directed.push_back(mk_req(32'd1, 0, BS_DEC, 0, 0, 0, 0, 0, 0, 6'd60));
        // octal leading zero, decimal alternate form ignored
        directed.push_back(mk_req(32'd7, 0, BS_OCT, 0, 0, 0, 0, 0, 1, 6'd0));
        directed.push_back(mk_req(32'd255, 0, BS_DEC, 0, 0, 0, 0, 0, 1, 6'd0));
        // field longer than the width, then mixed sign, prefix and padding cases
        directed.push_back(mk_req(32'hABCD_EF12, 0, BS_HEX, 1, 0, 0, 0, 0, 1, 6'd5));
        directed.push_back(mk_req(32'h8000_0000, 0, BS_BIN, 1, 1, 1, 0, 0, 1, 6'd40));
        directed.push_back(mk_req(32'd10, 0, BS_HEX, 1, 0, 0, 1, 1, 1, 6'd6));
        directed.push_back(mk_req(32'h7FFF_FFFF, 0, BS_DEC, 0, 0, 0, 1, 1, 0, 6'd61));

        foreach (directed[i]) begin
            send_req(directed[i]);
            if ($urandom_range(0, 99) < 6) idle_for($urandom_range(1, 80));
        end

        // random stream; transactions 120..220 run back to back with no gaps
        for (int k = 0; k < 360; k++) begin
            send_req(rand_req());
            if ((k < 120 || k > 220) && $urandom_range(0, 99) < 6)
                idle_for($urandom_range(1, 80));
        end
        start <= 1'b0;

        // drain: wait for every pending character, then watch for strays
        guard = 0;
        while (board.pending.size() != 0 && guard < 200_000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (200) @(posedge i_clk);

        if (board.pending.size() != 0) begin
            $display("%0t: %0d expected chars never arrived", $time, board.pending.size());
            board.mismatches++;
        end
        if (board.mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
